@@ rtl/bsbvm_pkg.sv @@
// ============================================================================
// bsbvm_pkg
// shared constants, codes and controller/datapath interface types for the
// byte subtract-and-branch machine
// ============================================================================
`default_nettype none

package bsbvm_pkg;

   // store geometry
   localparam int MEM_BYTES = 65536;
   localparam int ADDR_W    = $clog2(MEM_BYTES);
   localparam int PC_W      = ADDR_W + 1;
   localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);
   localparam logic [31:0] START_PC  = 32'd12;

   // header bytes, little-endian word of R W b 2
   localparam logic [7:0]  HDR_BYTE0 = 8'h52;
   localparam logic [7:0]  HDR_BYTE1 = 8'h57;
   localparam logic [7:0]  HDR_BYTE2 = 8'h62;
   localparam logic [7:0]  HDR_BYTE3 = 8'h32;
   localparam logic [31:0] HDR_WORD  = {HDR_BYTE3, HDR_BYTE2, HDR_BYTE1, HDR_BYTE0};

   // transaction operations
   localparam logic [1:0] OPER_LOAD  = 2'd0;
   localparam logic [1:0] OPER_START = 2'd1;
   localparam logic [1:0] OPER_STEP  = 2'd2;

   // instruction opcodes
   localparam logic [2:0] OPC_HALT   = 3'd0;
   localparam logic [2:0] OPC_OUT    = 3'd1;
   localparam logic [2:0] OPC_BRANCH = 3'd2;
   localparam logic [2:0] OPC_SUB    = 3'd3;
   localparam logic [2:0] OPC_IN     = 3'd4;
   localparam logic [7:0] OPC_LAST   = 8'd4;

   // result status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_HALT   = 3'd1;
   localparam logic [2:0] ST_BADOP  = 3'd2;
   localparam logic [2:0] ST_BADHDR = 3'd3;
   localparam logic [2:0] ST_RANGE  = 3'd4;
   localparam logic [2:0] ST_IDLE   = 3'd5;

   // program counter update select
   localparam logic [2:0] PC_HOLD  = 3'd0;
   localparam logic [2:0] PC_START = 3'd1;
   localparam logic [2:0] PC_JUMP  = 3'd2;
   localparam logic [2:0] PC_NEXT5 = 3'd3;
   localparam logic [2:0] PC_NEXT9 = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic       clr_step;
      logic       accept;
      logic       load_wr;
      logic       fetch_start;
      logic       fetch_hdr;
      logic       fetch_rd;
      logic       op_rd;
      logic       op_cap;
      logic       rd_p0;
      logic       rd_p1;
      logic       opnd_cap;
      logic       wr_sub;
      logic       wr_in;
      logic [2:0] pc_sel;
      logic       run_set;
      logic       run_clr;
      logic       respond;
      logic [2:0] rsp_status;
      logic       rsp_out_valid;
      logic       rsp_taken;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic       clear_done;
      logic       load_bad;
      logic       running;
      logic       op_bad;
      logic [2:0] op_code;
      logic       pc_bad;
      logic       fetch_last;
      logic       hdr_ok;
      logic       p0_bad;
      logic       p1_bad;
      logic       byte_high;
      logic       at_end;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ rtl/bsbvm_datapath.sv @@
// ============================================================================
// bsbvm_datapath
// byte store, program counter, pointer assembly and result registers
// ============================================================================
`default_nettype none

module bsbvm_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bsbvm_pkg::ctl_cmd_type  cmd,
   output      bsbvm_pkg::dp_stat_type  stat,
   input  wire logic [15:0]             req_address,
   input  wire logic [7:0]              req_data,
   input  wire logic                    req_input_at_end,
   output      logic [2:0]              rsp_status,
   output      logic                    rsp_out_valid,
   output      logic [7:0]              rsp_out_byte,
   output      logic                    rsp_input_taken,
   output      logic [15:0]             rsp_next_pc
);

   // byte store, single port, registered read
   logic [7:0] mem [bsbvm_pkg::MEM_BYTES];
   logic [bsbvm_pkg::ADDR_W-1:0] mem_addr;
   logic       mem_we;
   logic       mem_re;
   logic [7:0] mem_wdata;
   logic [7:0] rdata_ff;

   logic [bsbvm_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [15:0] addr_ff;
   logic [7:0]  din_ff;
   logic        at_end_ff;
   logic [7:0]  opcode_ff;
   logic [2:0]  idx_ff, idx_in;
   logic        fetch_hdr_ff, fetch_hdr_in;
   logic        cap_ff;
   logic [63:0] ptr_ff;
   logic [7:0]  opnd_ff;
   logic [bsbvm_pkg::PC_W-1:0] pc_ff, pc_in;
   logic        running_ff, running_in;

   logic [2:0]  rsp_status_ff;
   logic        rsp_out_valid_ff;
   logic [7:0]  rsp_out_byte_ff;
   logic        rsp_taken_ff;

   logic        two_ptr;
   logic [31:0] pc32;
   logic [31:0] addr32;
   logic [31:0] p0;
   logic [31:0] p1;
   logic [31:0] fetch_addr;
   logic [31:0] instr_end;
   logic [2:0]  fetch_top;

   assign two_ptr   = (opcode_ff[2:0] == bsbvm_pkg::OPC_BRANCH) ||
                      (opcode_ff[2:0] == bsbvm_pkg::OPC_SUB);
   assign pc32      = 32'(pc_ff);
   assign addr32    = 32'(addr_ff);
   assign p0        = two_ptr ? ptr_ff[31:0] : ptr_ff[63:32];
   assign p1        = ptr_ff[63:32];
   assign fetch_addr = fetch_hdr_ff ? 32'(idx_ff) : pc32 + 32'd1 + 32'(idx_ff);
   assign instr_end = pc32 + (two_ptr ? 32'd9 : 32'd5);
   assign fetch_top = (!fetch_hdr_ff && two_ptr) ? 3'd7 : 3'd3;

   // store port selection
   always_comb begin
      mem_addr  = '0;
      mem_wdata = '0;
      if (cmd.clr_step) begin
         mem_addr = clr_addr_ff;
      end else if (cmd.load_wr) begin
         mem_addr  = addr32[bsbvm_pkg::ADDR_W-1:0];
         mem_wdata = din_ff;
      end else if (cmd.fetch_rd) begin
         mem_addr = fetch_addr[bsbvm_pkg::ADDR_W-1:0];
      end else if (cmd.op_rd) begin
         mem_addr = pc32[bsbvm_pkg::ADDR_W-1:0];
      end else if (cmd.rd_p0) begin
         mem_addr = p0[bsbvm_pkg::ADDR_W-1:0];
      end else if (cmd.wr_sub) begin
         mem_addr  = p0[bsbvm_pkg::ADDR_W-1:0];
         mem_wdata = rdata_ff - opnd_ff;
      end else if (cmd.wr_in) begin
         mem_addr  = p0[bsbvm_pkg::ADDR_W-1:0];
         mem_wdata = at_end_ff ? 8'hFF : din_ff;
      end else if (cmd.rd_p1) begin
         mem_addr = p1[bsbvm_pkg::ADDR_W-1:0];
      end
   end

   assign mem_we = cmd.clr_step | cmd.load_wr | cmd.wr_sub | cmd.wr_in;
   assign mem_re = cmd.fetch_rd | cmd.op_rd | cmd.rd_p0 | cmd.rd_p1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   // next values of control state
   always_comb begin
      clr_addr_in  = cmd.clr_step ? clr_addr_ff + 1'b1 : clr_addr_ff;
      idx_in       = cmd.fetch_start ? 3'd0 : (cmd.fetch_rd ? idx_ff + 3'd1 : idx_ff);
      fetch_hdr_in = cmd.fetch_start ? cmd.fetch_hdr : fetch_hdr_ff;
      running_in   = running_ff;
      if (cmd.run_set) begin
         running_in = 1'b1;
      end else if (cmd.run_clr) begin
         running_in = 1'b0;
      end
      case (cmd.pc_sel)
         bsbvm_pkg::PC_HOLD:  pc_in = pc_ff;
         bsbvm_pkg::PC_START: pc_in = bsbvm_pkg::PC_W'(bsbvm_pkg::START_PC);
         bsbvm_pkg::PC_JUMP:  pc_in = p0[bsbvm_pkg::PC_W-1:0];
         bsbvm_pkg::PC_NEXT5: pc_in = bsbvm_pkg::PC_W'(pc32 + 32'd5);
         bsbvm_pkg::PC_NEXT9: pc_in = bsbvm_pkg::PC_W'(pc32 + 32'd9);
         default:             pc_in = pc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         idx_ff       <= '0;
         fetch_hdr_ff <= 1'b0;
         cap_ff       <= 1'b0;
         pc_ff        <= bsbvm_pkg::PC_W'(bsbvm_pkg::START_PC);
         running_ff   <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         idx_ff       <= idx_in;
         fetch_hdr_ff <= fetch_hdr_in;
         cap_ff       <= cmd.fetch_rd;
         pc_ff        <= pc_in;
         running_ff   <= running_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff   <= req_address;
         din_ff    <= req_data;
         at_end_ff <= req_input_at_end;
      end
      if (cmd.op_cap) begin
         opcode_ff <= rdata_ff;
      end
      if (cap_ff) begin
         // little-endian bytes enter from the top
         ptr_ff <= {rdata_ff, ptr_ff[63:8]};
      end
      if (cmd.opnd_cap) begin
         opnd_ff <= rdata_ff;
      end
      if (cmd.respond) begin
         rsp_status_ff    <= cmd.rsp_status;
         rsp_out_valid_ff <= cmd.rsp_out_valid;
         rsp_out_byte_ff  <= cmd.rsp_out_valid ? rdata_ff : 8'd0;
         rsp_taken_ff     <= cmd.rsp_taken;
      end
   end

   always_comb begin
      stat.clear_done = clr_addr_ff == bsbvm_pkg::ADDR_W'(bsbvm_pkg::MEM_BYTES - 1);
      stat.load_bad   = addr32 >= bsbvm_pkg::MEM_LIMIT;
      stat.running    = running_ff;
      stat.op_bad     = opcode_ff > bsbvm_pkg::OPC_LAST;
      stat.op_code    = opcode_ff[2:0];
      stat.pc_bad     = instr_end > bsbvm_pkg::MEM_LIMIT;
      stat.fetch_last = idx_ff == fetch_top;
      stat.hdr_ok     = ptr_ff[63:32] == bsbvm_pkg::HDR_WORD;
      stat.p0_bad     = p0 >= bsbvm_pkg::MEM_LIMIT;
      stat.p1_bad     = p1 >= bsbvm_pkg::MEM_LIMIT;
      stat.byte_high  = rdata_ff[7];
      stat.at_end     = at_end_ff;
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_out_valid   = rsp_out_valid_ff;
   assign rsp_out_byte    = rsp_out_byte_ff;
   assign rsp_input_taken = rsp_taken_ff;
   assign rsp_next_pc     = pc32[15:0];

endmodule

`default_nettype wire

@@ rtl/bsbvm_ctrl.sv @@
// ============================================================================
// bsbvm_ctrl
// sequencer for store clearing, loads, header check and instruction steps
// ============================================================================
`default_nettype none

module bsbvm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic [1:0]              req_operation,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      bsbvm_pkg::ctl_cmd_type  cmd,
   input  wire bsbvm_pkg::dp_stat_type  stat
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_LOAD     = 4'd2;
   localparam logic [3:0] S_HDR_RD   = 4'd3;
   localparam logic [3:0] S_HDR_WAIT = 4'd4;
   localparam logic [3:0] S_HDR_CHK  = 4'd5;
   localparam logic [3:0] S_OP_RD    = 4'd6;
   localparam logic [3:0] S_OP_WAIT  = 4'd7;
   localparam logic [3:0] S_OP_DEC   = 4'd8;
   localparam logic [3:0] S_PTR_RD   = 4'd9;
   localparam logic [3:0] S_PTR_WAIT = 4'd10;
   localparam logic [3:0] S_EXEC     = 4'd11;
   localparam logic [3:0] S_OUT_WAIT = 4'd12;
   localparam logic [3:0] S_BR_WAIT  = 4'd13;
   localparam logic [3:0] S_SUB_A    = 4'd14;
   localparam logic [3:0] S_SUB_B    = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               case (req_operation)
                  bsbvm_pkg::OPER_LOAD: begin
                     state_in = S_LOAD;
                  end
                  bsbvm_pkg::OPER_START: begin
                     cmd.fetch_start = 1'b1;
                     cmd.fetch_hdr   = 1'b1;
                     state_in        = S_HDR_RD;
                  end
                  bsbvm_pkg::OPER_STEP: begin
                     if (stat.running) begin
                        state_in = S_OP_RD;
                     end else begin
                        cmd.respond    = 1'b1;
                        cmd.rsp_status = bsbvm_pkg::ST_IDLE;
                     end
                  end
                  default: begin
                     // unused operation, plain ok
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = bsbvm_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_LOAD: begin
            cmd.respond = 1'b1;
            if (stat.load_bad) begin
               cmd.rsp_status = bsbvm_pkg::ST_RANGE;
            end else begin
               cmd.load_wr    = 1'b1;
               cmd.rsp_status = bsbvm_pkg::ST_OK;
            end
            state_in = S_IDLE;
         end
         S_HDR_RD: begin
            cmd.fetch_rd = 1'b1;
            if (stat.fetch_last) begin
               state_in = S_HDR_WAIT;
            end
         end
         S_HDR_WAIT: begin
            state_in = S_HDR_CHK;
         end
         S_HDR_CHK: begin
            cmd.respond = 1'b1;
            if (stat.hdr_ok) begin
               cmd.pc_sel     = bsbvm_pkg::PC_START;
               cmd.run_set    = 1'b1;
               cmd.rsp_status = bsbvm_pkg::ST_OK;
            end else begin
               cmd.run_clr    = 1'b1;
               cmd.rsp_status = bsbvm_pkg::ST_BADHDR;
            end
            state_in = S_IDLE;
         end
         S_OP_RD: begin
            cmd.op_rd = 1'b1;
            state_in  = S_OP_WAIT;
         end
         S_OP_WAIT: begin
            cmd.op_cap = 1'b1;
            state_in   = S_OP_DEC;
         end
         S_OP_DEC: begin
            if (stat.op_bad) begin
               cmd.run_clr    = 1'b1;
               cmd.respond    = 1'b1;
               cmd.rsp_status = bsbvm_pkg::ST_BADOP;
               state_in       = S_IDLE;
            end else if (stat.op_code == bsbvm_pkg::OPC_HALT) begin
               cmd.run_clr    = 1'b1;
               cmd.respond    = 1'b1;
               cmd.rsp_status = bsbvm_pkg::ST_HALT;
               state_in       = S_IDLE;
            end else if (stat.pc_bad) begin
               cmd.run_clr    = 1'b1;
               cmd.respond    = 1'b1;
               cmd.rsp_status = bsbvm_pkg::ST_RANGE;
               state_in       = S_IDLE;
            end else begin
               cmd.fetch_start = 1'b1;
               state_in        = S_PTR_RD;
            end
         end
         S_PTR_RD: begin
            cmd.fetch_rd = 1'b1;
            if (stat.fetch_last) begin
               state_in = S_PTR_WAIT;
            end
         end
         S_PTR_WAIT: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (stat.op_code)
               bsbvm_pkg::OPC_OUT: begin
                  if (stat.p0_bad) begin
                     cmd.run_clr    = 1'b1;
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = bsbvm_pkg::ST_RANGE;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.rd_p0 = 1'b1;
                     state_in  = S_OUT_WAIT;
                  end
               end
               bsbvm_pkg::OPC_BRANCH: begin
                  if (stat.p1_bad) begin
                     cmd.run_clr    = 1'b1;
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = bsbvm_pkg::ST_RANGE;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.rd_p1 = 1'b1;
                     state_in  = S_BR_WAIT;
                  end
               end
               bsbvm_pkg::OPC_SUB: begin
                  if (stat.p0_bad || stat.p1_bad) begin
                     cmd.run_clr    = 1'b1;
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = bsbvm_pkg::ST_RANGE;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.rd_p1 = 1'b1;
                     state_in  = S_SUB_A;
                  end
               end
               bsbvm_pkg::OPC_IN: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
                  if (stat.p0_bad) begin
                     cmd.run_clr    = 1'b1;
                     cmd.rsp_status = bsbvm_pkg::ST_RANGE;
                  end else begin
                     cmd.wr_in      = 1'b1;
                     cmd.pc_sel     = bsbvm_pkg::PC_NEXT5;
                     cmd.rsp_status = bsbvm_pkg::ST_OK;
                     cmd.rsp_taken  = !stat.at_end;
                  end
               end
               default: begin
                  cmd.run_clr    = 1'b1;
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = bsbvm_pkg::ST_BADOP;
                  state_in       = S_IDLE;
               end
            endcase
         end
         S_OUT_WAIT: begin
            cmd.respond       = 1'b1;
            cmd.rsp_status    = bsbvm_pkg::ST_OK;
            cmd.rsp_out_valid = 1'b1;
            cmd.pc_sel        = bsbvm_pkg::PC_NEXT5;
            state_in          = S_IDLE;
         end
         S_BR_WAIT: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
            if (stat.byte_high) begin
               cmd.pc_sel     = bsbvm_pkg::PC_NEXT9;
               cmd.rsp_status = bsbvm_pkg::ST_OK;
            end else if (stat.p0_bad) begin
               cmd.run_clr    = 1'b1;
               cmd.rsp_status = bsbvm_pkg::ST_RANGE;
            end else begin
               cmd.pc_sel     = bsbvm_pkg::PC_JUMP;
               cmd.rsp_status = bsbvm_pkg::ST_OK;
            end
         end
         S_SUB_A: begin
            cmd.opnd_cap = 1'b1;
            cmd.rd_p0    = 1'b1;
            state_in     = S_SUB_B;
         end
         S_SUB_B: begin
            cmd.wr_sub     = 1'b1;
            cmd.pc_sel     = bsbvm_pkg::PC_NEXT9;
            cmd.respond    = 1'b1;
            cmd.rsp_status = bsbvm_pkg::ST_OK;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // once a transaction is in flight the result slot is empty
   a_busy_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_CLEAR) |-> !rsp_valid_ff)
      else $error("result slot occupied while a transaction is in flight");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during store clearing");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.load_wr, cmd.wr_sub, cmd.wr_in,
                cmd.fetch_rd, cmd.op_rd, cmd.rd_p0, cmd.rd_p1}))
      else $error("more than one store access in a cycle");

   a_respond_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("result issued without returning to idle");
`endif

endmodule

`default_nettype wire

@@ rtl/byte_subtract_branch_vm_core_top.sv @@
// ============================================================================
// byte_subtract_branch_vm_core_top
// byte-store machine with a five-opcode subtract-and-branch instruction set
// ============================================================================
//
//   channel  dir  handshake             payload
//   req_     in   req_valid/req_ready   operation, address, data, input_at_end
//   rsp_     out  rsp_valid/rsp_ready   status, out_valid, out_byte,
//                                       input_taken, next_pc
//
// one transaction is worked at a time; every store access goes through one
// single-port byte memory with a registered read, so an item's duration is
// set by the bytes it touches: a load writes at most one byte, a start
// reads the four header bytes, a step reads the opcode and, unless it halts
// or fails its checks, four or eight pointer bytes, then makes its operand
// access; a subtract adds the write back
// after reset the store is cleared one byte a cycle, with req_ready low;
// the result sits in an output register and a new request is taken in
// the cycle that result is taken
// ============================================================================
`default_nettype none

module byte_subtract_branch_vm_core_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data,
   input  wire logic        req_input_at_end,
   // response channel
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_status,
   output      logic        rsp_out_valid,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_input_taken,
   output      logic [15:0] rsp_next_pc
);

   // command and status between sequencer and datapath
   bsbvm_pkg::ctl_cmd_type cmd;
   bsbvm_pkg::dp_stat_type stat;

   // sequencer: clearing pass, handshakes and instruction flow
   bsbvm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .stat          (stat)
   );

   // datapath: byte store, pointers, program counter and result registers
   bsbvm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_address      (req_address),
      .req_data         (req_data),
      .req_input_at_end (req_input_at_end),
      .rsp_status       (rsp_status),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_input_taken  (rsp_input_taken),
      .rsp_next_pc      (rsp_next_pc)
   );

endmodule

`default_nettype wire

@@ tb/tb_byte_subtract_branch_vm_core_top.sv @@
// ============================================================================
// tb_byte_subtract_branch_vm_core_top
// self-checking bench for the byte subtract-and-branch machine: a mirror of
// the machine state predicts every response, programs are built at random
// and loaded byte by byte, then started and stepped until the machine stops
// ============================================================================

import bsbvm_pkg::*;

// one response as seen on the rsp_ channel
typedef struct packed {
   logic [2:0]  status;
   logic        out_valid;
   logic [7:0]  out_byte;
   logic        input_taken;
   logic [15:0] next_pc;
} vm_result_type;

// mirror of the machine: byte store, program counter and run flag, plus the
// responses still owed by the block in request order
class byte_machine_mirror;
   logic [7:0]    store [MEM_BYTES];
   logic [31:0]   pc;
   bit            running;
   vm_result_type due_results [$];
   int            mismatches;

   function new();
      foreach (store[i]) store[i] = 8'h00;
      pc         = START_PC;
      running    = 1'b0;
      mismatches = 0;
   endfunction

   function int outstanding();
      return due_results.size();
   endfunction

   // little-endian pointer, caller keeps at + 3 inside the store
   function logic [31:0] pointer_at(logic [31:0] at);
      return {store[16'(at + 32'd3)], store[16'(at + 32'd2)],
              store[16'(at + 32'd1)], store[16'(at)]};
   endfunction

   function vm_result_type execute_instruction(logic [7:0] din, logic at_end);
      vm_result_type res;
      logic [7:0]    opc;
      logic [31:0]   p0;
      logic [31:0]   p1;
      logic [31:0]   span;
      res        = '0;
      res.status = ST_OK;
      opc        = store[pc[15:0]];
      span = (opc == 8'(OPC_BRANCH) || opc == 8'(OPC_SUB)) ? 32'd9 : 32'd5;
      if (opc > OPC_LAST) begin
         res.status = ST_BADOP;
      end else if (opc == 8'(OPC_HALT)) begin
         res.status = ST_HALT;
      end else if (pc + span > MEM_LIMIT) begin
         res.status = ST_RANGE;
      end else begin
         p0 = pointer_at(pc + 32'd1);
         p1 = pointer_at(pc + 32'd5);
         case (opc)
            8'(OPC_OUT): begin
               if (p0 >= MEM_LIMIT) begin
                  res.status = ST_RANGE;
               end else begin
                  res.out_valid = 1'b1;
                  res.out_byte  = store[p0[15:0]];
                  pc = pc + 32'd5;
               end
            end
            8'(OPC_BRANCH): begin
               // target only matters when the branch is taken
               if (p1 >= MEM_LIMIT) begin
                  res.status = ST_RANGE;
               end else if (store[p1[15:0]] >= 8'd128) begin
                  pc = pc + 32'd9;
               end else if (p0 >= MEM_LIMIT) begin
                  res.status = ST_RANGE;
               end else begin
                  pc = p0;
               end
            end
            8'(OPC_SUB): begin
               if (p0 >= MEM_LIMIT || p1 >= MEM_LIMIT) begin
                  res.status = ST_RANGE;
               end else begin
                  store[p0[15:0]] = store[p0[15:0]] - store[p1[15:0]];
                  pc = pc + 32'd9;
               end
            end
            default: begin
               if (p0 >= MEM_LIMIT) begin
                  res.status = ST_RANGE;
               end else begin
                  store[p0[15:0]]   = at_end ? 8'hFF : din;
                  res.input_taken = !at_end;
                  pc = pc + 32'd5;
               end
            end
         endcase
      end
      if (res.status != ST_OK) running = 1'b0;
      return res;
   endfunction

   function void note_request(logic [1:0] oper, logic [15:0] addr, logic [7:0] din,
                              logic at_end);
      vm_result_type res;
      res        = '0;
      res.status = ST_OK;
      case (oper)
         OPER_LOAD: begin
            if (32'(addr) < MEM_LIMIT) store[addr] = din;
            else res.status = ST_RANGE;
         end
         OPER_START: begin
            if ({store[3], store[2], store[1], store[0]} == HDR_WORD) begin
               pc      = START_PC;
               running = 1'b1;
            end else begin
               running    = 1'b0;
               res.status = ST_BADHDR;
            end
         end
         OPER_STEP: begin
            if (!running) res.status = ST_IDLE;
            else res = execute_instruction(din, at_end);
         end
         default: ;
      endcase
      res.next_pc = pc[15:0];
      due_results.push_back(res);
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] seen,
                               longint unsigned stamp);
      if (seen !== want) begin
         mismatches++;
         $display("%0d ns: %s mismatch, expected %0d, got %0d", stamp, name, want, seen);
      end
   endfunction

   function void check_response(vm_result_type got, longint unsigned stamp);
      vm_result_type want;
      if (due_results.size() == 0) begin
         mismatches++;
         $display("%0d ns: response with no request outstanding, expected none, got %h",
                  stamp, got);
         return;
      end
      want = due_results.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status), stamp);
      compare_field("out_valid", 16'(want.out_valid), 16'(got.out_valid), stamp);
      compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte), stamp);
      compare_field("input_taken", 16'(want.input_taken), 16'(got.input_taken), stamp);
      compare_field("next_pc", want.next_pc, got.next_pc, stamp);
   endfunction
endclass

module tb_byte_subtract_branch_vm_core_top;
   timeunit 1ns;
   timeprecision 1ps;

   // operation three has no name in the package, the block ignores it
   localparam logic [1:0]  OPER_NOP     = 2'd3;
   // small window of data bytes that random programs mostly work on
   localparam logic [15:0] DATA_BASE    = 16'h0100;
   // last bytes of the store, where instructions run past the end
   localparam logic [15:0] TOP_WINDOW   = 16'hFFF8;
   localparam int          RANDOM_ITEMS = 420;
   localparam int          STEP_LIMIT   = 24;
   localparam int          HOLD_CYCLES  = 80;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation    = OPER_LOAD;
   logic [15:0] req_address      = 16'h0000;
   logic [7:0]  req_data         = 8'h00;
   logic        req_input_at_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_out_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_input_taken;
   logic [15:0] rsp_next_pc;

   byte_machine_mirror mirror;
   int                 sent_items = 0;
   int                 rsp_seen   = 0;
   // remaining items of a burst with no idling, one entry per side
   int                 calm_left [2] = '{0, 0};

   byte_subtract_branch_vm_core_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_address      (req_address),
      .req_data         (req_data),
      .req_input_at_end (req_input_at_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_input_taken  (rsp_input_taken),
      .rsp_next_pc      (rsp_next_pc)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pause before the next transaction on one side, in idle cycles: usually a
   // random draw, now and then a burst of back-to-back transactions
   function automatic int draw_pause(int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_left[side] = int'($urandom_range(8, 30));
         return 0;
      end
      return int'($urandom_range(0, 6));
   endfunction

   // offer one request and hold it until the block takes it; the mirror is
   // updated at the accepting edge so the state seen by the caller is current
   task automatic send_item(input logic [1:0] oper, input logic [15:0] addr,
                            input logic [7:0] din, input logic at_end);
      int gap;
      gap = draw_pause(0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= oper;
      req_address      <= addr;
      req_data         <= din;
      req_input_at_end <= at_end;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      mirror.note_request(oper, addr, din, at_end);
      if (oper != OPER_NOP) sent_items++;
   endtask

   task automatic load_byte(input logic [15:0] addr, input logic [7:0] din);
      send_item(OPER_LOAD, addr, din, 1'($urandom));
   endtask

   task automatic step_machine(input logic [7:0] din, input logic at_end);
      send_item(OPER_STEP, 16'($urandom), din, at_end);
   endtask

   // stray transaction: ignored operation, step, or load anywhere incl. the
   // two ends of the store
   task automatic make_noise();
      int unsigned pick;
      logic [15:0] addr;
      pick = $urandom_range(0, 3);
      addr = 16'($urandom);
      if (pick == 0) begin
         send_item(OPER_NOP, addr, 8'($urandom), 1'($urandom));
      end else if (pick == 1) begin
         step_machine(8'($urandom), 1'($urandom));
      end else begin
         pick = $urandom_range(0, 3);
         if (pick == 0) addr = 16'h0000;
         else if (pick == 1) addr = 16'hFFFF;
         load_byte(addr, 8'($urandom));
      end
   endtask

   // data pointer: mostly into the small window, sometimes anywhere, rarely
   // beyond the store
   function automatic logic [31:0] data_pointer();
      int unsigned pick;
      pick = $urandom_range(0, 31);
      if (pick == 0) return 32'($urandom) | 32'h0001_0000;
      if (pick < 4) return 32'($urandom_range(0, 65535));
      return 32'(DATA_BASE) + 32'($urandom_range(0, 15));
   endfunction

   // build a short program at the start address, fix the header, load it,
   // start it and step until the machine stops or STEP_LIMIT steps are done
   task automatic run_program_round();
      logic [7:0]  image [$];
      logic [7:0]  opcodes [$];
      int unsigned starts [$];
      int unsigned at;
      int unsigned count;
      int unsigned pick;
      int          steps;
      logic [7:0]  opc;
      logic [31:0] p0;
      logic [31:0] p1;

      // opcodes first, so branches can aim at real instruction boundaries
      count = $urandom_range(2, 6);
      at    = START_PC;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) opc = 8'(OPC_HALT);
         else if (pick < 8) opc = 8'($urandom_range(32'(OPC_LAST) + 1, 255));
         else opc = 8'($urandom_range(32'(OPC_OUT), 32'(OPC_IN)));
         opcodes.push_back(opc);
         starts.push_back(at);
         if (opc == 8'(OPC_BRANCH) || opc == 8'(OPC_SUB)) at += 9;
         else if (opc == 8'(OPC_OUT) || opc == 8'(OPC_IN)) at += 5;
         else at += 1;
      end
      starts.push_back(at);

      foreach (opcodes[k]) begin
         opc = opcodes[k];
         image.push_back(opc);
         p0 = data_pointer();
         p1 = data_pointer();
         if (opc == 8'(OPC_BRANCH)) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) p0 = 32'($urandom) | 32'h0001_0000;
            else if (pick == 1) p0 = 32'(TOP_WINDOW) + 32'($urandom_range(0, 7));
            else if (pick == 2) p0 = 32'($urandom_range(0, 65535));
            else p0 = starts[$urandom_range(0, starts.size() - 1)];
         end
         if (opc >= 8'(OPC_OUT) && opc <= OPC_LAST)
            for (int b = 0; b < 4; b++) image.push_back(p0[8*b +: 8]);
         if (opc == 8'(OPC_BRANCH) || opc == 8'(OPC_SUB))
            for (int b = 0; b < 4; b++) image.push_back(p1[8*b +: 8]);
      end
      // end marker: halt, or now and then an unknown opcode
      if ($urandom_range(0, 3) == 0) image.push_back(8'($urandom_range(32'(OPC_LAST) + 1, 255)));
      else image.push_back(8'(OPC_HALT));

      // repair the header where stray writes hit it, sometimes spoil it
      for (int i = 0; i < 4; i++)
         if (mirror.store[i] != HDR_WORD[8*i +: 8]) load_byte(16'(i), HDR_WORD[8*i +: 8]);
      if ($urandom_range(0, 9) == 0) load_byte(16'($urandom_range(0, 3)), 8'($urandom));

      repeat ($urandom_range(1, 4))
         load_byte(DATA_BASE + 16'($urandom_range(0, 15)), 8'($urandom));
      if ($urandom_range(0, 3) == 0)
         load_byte(TOP_WINDOW + 16'($urandom_range(0, 7)),
                   8'($urandom_range(32'(OPC_OUT), 32'(OPC_IN))));

      foreach (image[k]) begin
         if ($urandom_range(0, 11) == 0) make_noise();
         load_byte(16'(START_PC) + 16'(k), image[k]);
      end

      send_item(OPER_START, 16'($urandom), 8'($urandom), 1'($urandom));
      steps = 0;
      while (mirror.running && steps < STEP_LIMIT) begin
         step_machine(8'($urandom), $urandom_range(0, 3) == 0);
         steps++;
      end
      if ($urandom_range(0, 1) == 0) make_noise();
   endtask

   // stimulus
   initial begin
      int directed_items;
      mirror = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // machine stopped, ignored operation, start on an empty header
      step_machine(8'h00, 1'b1);
      send_item(OPER_NOP, 16'h0000, 8'hFF, 1'b0);
      send_item(OPER_START, 16'hFFFF, 8'hFF, 1'b1);

      load_byte(16'd0, HDR_BYTE0);
      load_byte(16'd1, HDR_BYTE1);
      load_byte(16'd2, HDR_BYTE2);
      load_byte(16'd3, HDR_BYTE3);

      // hand-built loop over the byte at 0x100, store is zero elsewhere:
      //   12 input      -> [0x100]
      //   17 branch     to 0x10000 if [0x100] < 128 (never taken here)
      //   26 subtract   [0x100] -= [0]
      //   35 output     [0x100]
      //   40 branch     to 12 if [0x100] < 128
      //   49 halt
      load_byte(16'd12, 8'(OPC_IN));
      load_byte(16'd14, 8'h01);
      load_byte(16'd17, 8'(OPC_BRANCH));
      load_byte(16'd20, 8'h01);
      load_byte(16'd23, 8'h01);
      load_byte(16'd26, 8'(OPC_SUB));
      load_byte(16'd28, 8'h01);
      load_byte(16'd35, 8'(OPC_OUT));
      load_byte(16'd37, 8'h01);
      load_byte(16'd40, 8'(OPC_BRANCH));
      load_byte(16'd41, 8'd12);
      load_byte(16'd46, 8'h01);
      send_item(OPER_START, 16'h0000, 8'h00, 1'b0);

      // first pass: 0x80 in, 0x2e after subtract, back branch taken
      step_machine(8'h80, 1'b0);
      repeat (4) step_machine(8'($urandom), 1'b0);
      // second pass: end of input stores 255, both branches fall through to halt
      step_machine(8'h5A, 1'b1);
      repeat (5) step_machine(8'($urandom), 1'b0);
      directed_items = sent_items;

      // random programs, with the odd burst of stray transactions
      while (sent_items < directed_items + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(3, 10)) make_noise();
         else run_program_round();
      end

      req_valid <= 1'b0;
      while (mirror.outstanding() != 0) @(posedge clock);
      // then keep watching to catch any stray response
      repeat (40) @(posedge clock);
      if (mirror.mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: random stalls, and twice a long hold so that the output
   // register fills and req_ready drops, holding back the request side
   initial begin
      int            hold;
      vm_result_type got;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         hold = draw_pause(1);
         if (rsp_seen == 60 || rsp_seen == 300) hold = HOLD_CYCLES;
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got.status      = rsp_status;
         got.out_valid   = rsp_out_valid;
         got.out_byte    = rsp_out_byte;
         got.input_taken = rsp_input_taken;
         got.next_pc     = rsp_next_pc;
         mirror.check_response(got, $time);
         rsp_seen++;
      end
   end

   // watchdog: covers the store clear after reset with a wide margin
   initial begin
      #(5_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
rtl/bsbvm_pkg.sv
rtl/bsbvm_datapath.sv
rtl/bsbvm_ctrl.sv
rtl/byte_subtract_branch_vm_core_top.sv
tb/tb_byte_subtract_branch_vm_core_top.sv
